FILE: src/dq_pkg.sv
// Shared types and operation codes for the double-ended queue.
package dq_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSPECT    = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  typedef struct packed {
    logic  shift_up;
    logic  shift_down;
    logic  load;
    word_t value;
  } cell_ctrl_t;

endpackage

FILE: src/double_ended_queue_unit.sv
// Top level of the double-ended queue: operation decode, occupancy and result register.
//
//  channel   ports                                         direction  handshake
//  command   start_i, op_i, push_value_i                   in         start_i && !busy_o
//  result    done_o, ok_o, count_o, front_value_o,          out        done_o, one cycle
//            back_value_o
//
// One item is taken every cycle; busy_o stays low. The result is registered and appears in the
// cycle after the item is taken, held for one cycle under done_o. Two chains of cells hold
// the words, one ordered from the front and one from the back, so both ends sit in fixed
// cells and every operation is at most a shift or a single load in each chain. Reset empties
// the queue at once. The receiver cannot stall the block.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [2:0]                   op_i,
  input  dq_pkg::word_t                push_value_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o,
  output dq_pkg::word_t                front_value_o,
  output dq_pkg::word_t                back_value_o
);
  import dq_pkg::*;

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  logic [CountW-1:0] count_d, count_q;
  logic              ok_d, ok_q;
  logic              done_q;
  logic              accept, full, empty;
  cell_ctrl_t        fwd_ctrl, bwd_ctrl;
  word_t             fwd_head, bwd_head;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CountW'(DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    count_d             = count_q;
    ok_d                = 1'b0;
    fwd_ctrl            = '0;
    bwd_ctrl            = '0;
    fwd_ctrl.value      = push_value_i;
    bwd_ctrl.value      = push_value_i;
    if (accept) begin
      unique case (op_e'(op_i))
        OP_PUSH_BACK: begin
          if (!full) begin
            fwd_ctrl.load     = 1'b1;
            bwd_ctrl.shift_up = 1'b1;
            count_d           = count_q + 1'b1;
            ok_d              = 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (!full) begin
            fwd_ctrl.shift_up = 1'b1;
            bwd_ctrl.load     = 1'b1;
            count_d           = count_q + 1'b1;
            ok_d              = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            bwd_ctrl.shift_down = 1'b1;
            count_d             = count_q - 1'b1;
            ok_d                = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            fwd_ctrl.shift_down = 1'b1;
            count_d             = count_q - 1'b1;
            ok_d                = 1'b1;
          end
        end
        OP_INSPECT: begin
          ok_d = !empty;
        end
        OP_CLEAR: begin
          count_d = '0;
          ok_d    = 1'b1;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  dq_chain #(
    .DEPTH(DEPTH)
  ) u_fwd_chain (
    .clk_i   (clk_i),
    .ctrl_i  (fwd_ctrl),
    .wr_idx_i(count_q),
    .head_o  (fwd_head)
  );

  dq_chain #(
    .DEPTH(DEPTH)
  ) u_bwd_chain (
    .clk_i   (clk_i),
    .ctrl_i  (bwd_ctrl),
    .wr_idx_i(count_q),
    .head_o  (bwd_head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q <= ok_d;
  end

  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign count_o       = count_q;
  assign front_value_o = (count_q != '0) ? fwd_head : '0;
  assign back_value_o  = (count_q != '0) ? bwd_head : '0;

endmodule

FILE: src/dq_cell.sv
// One storage cell of a queue chain: loads, or takes a neighbour's word.
module dq_cell (
  input  logic               clk_i,
  input  dq_pkg::cell_ctrl_t ctrl_i,
  input  logic               sel_i,
  input  dq_pkg::word_t      below_i,
  input  dq_pkg::word_t      above_i,
  output dq_pkg::word_t      data_o
);
  import dq_pkg::*;

  word_t data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load && sel_i) begin
      data_d = ctrl_i.value;
    end else if (ctrl_i.shift_up) begin
      data_d = below_i;
    end else if (ctrl_i.shift_down) begin
      data_d = above_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: src/dq_chain.sv
// Row of cells holding the queue in order from its head end.
module dq_chain #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  dq_pkg::cell_ctrl_t               ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]       wr_idx_i,
  output dq_pkg::word_t                    head_o
);
  import dq_pkg::*;

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  word_t data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t below, above;
    logic  sel;

    if (i == 0) begin : g_first
      assign below = ctrl_i.value;
    end else begin : g_mid
      assign below = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign above = data[i];
    end else begin : g_inner
      assign above = data[i+1];
    end

    assign sel = (wr_idx_i == CountW'(i));

    dq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .sel_i  (sel),
      .below_i(below),
      .above_i(above),
      .data_o (data[i])
    );
  end

  assign head_o = data[0];

endmodule
